[src/kwm_pkg.sv]
// Shared types and constants of the k-way run merge unit.
package kwm_pkg;

    localparam int KEY_PORT_W = 64;
    localparam int TAG_PORT_W = 16;
    localparam int RUN_W      = 3;
    localparam int CFG_W      = 4;

    // Command kinds passed from the front end to the merge engine.
    localparam logic [1:0] CMD_ERR       = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_WRITE_SEL = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [RUN_W-1:0]      run;
        logic [KEY_PORT_W-1:0] key;
        logic [TAG_PORT_W-1:0] tag;
        logic                  ended;
    } t_cmd;

    // Outcome of one selection, returned to the front end.
    typedef struct packed {
        logic             valid;
        logic             done;
        logic [RUN_W-1:0] run;
    } t_sel_fb;

endpackage

[src/k_way_run_merge_unit.sv]
// Top level of the k-way run merge unit: register, front end, queue and merge engine.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_run_index, i_record_key, i_record_tag,
//          |           |                      | i_run_ended
//  out     | output    | o_out_valid/i_out_stall | o_out_key, o_out_tag, o_out_run,
//          |           |                      | o_merge_done, o_order_error
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (run_count)
//
// A beat that loads a head without selecting is written to the head store; a beat
// that names the wrong run waits for a free output register. A beat that triggers a
// selection makes the engine, for n active runs, scan the head store one run per cycle
// through its single read port, and input is held off until the result is formed.
// Synchronous active-low reset empties the queue and clears all heads; run_count
// resets to 2. A stalled result stays in the output register while loads carry on.
module k_way_run_merge_unit #(
    parameter int MAX_RUNS  = 8,
    parameter int KEY_BYTES = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [kwm_pkg::RUN_W-1:0]      i_run_index,
    input  logic [kwm_pkg::KEY_PORT_W-1:0] i_record_key,
    input  logic [kwm_pkg::TAG_PORT_W-1:0] i_record_tag,
    input  logic                           i_run_ended,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kwm_pkg::KEY_PORT_W-1:0] o_out_key,
    output logic [kwm_pkg::TAG_PORT_W-1:0] o_out_tag,
    output logic [kwm_pkg::RUN_W-1:0]      o_out_run,
    output logic                           o_merge_done,
    output logic                           o_order_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int TAG_W = (TAG_BITS < kwm_pkg::TAG_PORT_W) ? TAG_BITS : kwm_pkg::TAG_PORT_W;

    logic [kwm_pkg::CFG_W-1:0] r_run_count;
    logic [7:0]                rc_ext;
    logic [7:0]                n_active;
    logic [CNT_W-1:0]          active_n;
    logic                      cfg_wr;

    kwm_pkg::t_cmd    push_cmd;
    kwm_pkg::t_cmd    head_cmd;
    kwm_pkg::t_sel_fb sel_fb;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    logic             q_full;
    logic             front_busy;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Zero acts as one run; counts above the store depth saturate.
    assign rc_ext   = 8'(r_run_count);
    assign n_active = (rc_ext == 8'd0) ? 8'd1 :
                      (rc_ext > 8'(MAX_RUNS)) ? 8'(MAX_RUNS) : rc_ext;
    assign active_n = n_active[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= kwm_pkg::CFG_W'(2);
        end else if (cfg_wr) begin
            r_run_count <= i_cfg_data;
        end
    end

    kwm_front #(
        .MAX_RUNS (MAX_RUNS),
        .KEY_W    (KEY_W),
        .TAG_W    (TAG_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_wr),
        .i_n          (active_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_run_index  (i_run_index),
        .i_record_key (i_record_key),
        .i_record_tag (i_record_tag),
        .i_run_ended  (i_run_ended),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd),
        .i_fb         (sel_fb),
        .o_busy       (front_busy)
    );

    kwm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    kwm_back #(
        .MAX_RUNS (MAX_RUNS),
        .KEY_W    (KEY_W),
        .TAG_W    (TAG_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_wr),
        .i_n           (active_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_cmd_pop     (q_pop),
        .o_fb          (sel_fb),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_key     (o_out_key),
        .o_out_tag     (o_out_tag),
        .o_out_run     (o_out_run),
        .o_merge_done  (o_merge_done),
        .o_order_error (o_order_error)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    a_fb_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sel_fb.valid |-> front_busy)
        else $error("selection result without an outstanding selection");

    a_done_err_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_merge_done && o_order_error))
        else $error("result beat flags both done and order error");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command queue read while empty");
`endif

endmodule

[src/kwm_front.sv]
// Front end: checks each input beat against the expected run and queues a command.
module kwm_front #(
    parameter int MAX_RUNS = 8,
    parameter int KEY_W    = 64,
    parameter int TAG_W    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [$clog2(MAX_RUNS+1)-1:0]  i_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [kwm_pkg::RUN_W-1:0]      i_run_index,
    input  logic [kwm_pkg::KEY_PORT_W-1:0] i_record_key,
    input  logic [kwm_pkg::TAG_PORT_W-1:0] i_record_tag,
    input  logic                           i_run_ended,
    input  logic                           i_q_full,
    output logic                           o_push,
    output kwm_pkg::t_cmd                  o_cmd,
    input  kwm_pkg::t_sel_fb               i_fb,
    output logic                           o_busy
);

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam logic [kwm_pkg::KEY_PORT_W-1:0] KeyMask =
        {kwm_pkg::KEY_PORT_W{1'b1}} >> (kwm_pkg::KEY_PORT_W - KEY_W);
    localparam logic [kwm_pkg::TAG_PORT_W-1:0] TagMask =
        {kwm_pkg::TAG_PORT_W{1'b1}} >> (kwm_pkg::TAG_PORT_W - TAG_W);

    logic [CNT_W-1:0]          r_loaded, n_loaded;
    logic [kwm_pkg::RUN_W-1:0] r_expected, n_expected;
    logic                      r_wait, n_wait;

    logic             loading;
    logic [7:0]       want;
    logic             match;
    logic [CNT_W-1:0] loaded_inc;
    logic             accept;

    assign o_stall    = i_q_full || r_wait;
    assign accept     = i_valid && !o_stall;
    assign loading    = r_loaded < i_n;
    assign want       = loading ? 8'(r_loaded) : 8'(r_expected);
    assign match      = 8'(i_run_index) == want;
    assign loaded_inc = r_loaded + CNT_W'(1);
    assign o_busy     = r_wait;

    always_comb begin
        n_loaded       = r_loaded;
        n_expected     = r_expected;
        n_wait         = r_wait;
        o_push         = 1'b0;
        o_cmd.kind     = kwm_pkg::CMD_ERR;
        o_cmd.run      = i_run_index;
        o_cmd.key      = i_record_key & KeyMask;
        o_cmd.tag      = i_record_tag & TagMask;
        o_cmd.ended    = i_run_ended;

        if (accept) begin
            o_push = 1'b1;
            if (!match) begin
                o_cmd.kind = kwm_pkg::CMD_ERR;
            end else if (loading) begin
                n_loaded = loaded_inc;
                if (loaded_inc == i_n) begin
                    o_cmd.kind = kwm_pkg::CMD_WRITE_SEL;
                    n_wait     = 1'b1;
                end else begin
                    o_cmd.kind = kwm_pkg::CMD_WRITE;
                end
            end else begin
                o_cmd.kind = kwm_pkg::CMD_WRITE_SEL;
                n_wait     = 1'b1;
            end
        end

        // A selection result arrives only while input is held off.
        if (i_fb.valid) begin
            n_wait = 1'b0;
            if (i_fb.done) begin
                n_loaded   = '0;
                n_expected = '0;
            end else begin
                n_expected = i_fb.run;
            end
        end

        if (i_restart) begin
            n_loaded   = '0;
            n_expected = '0;
            n_wait     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_expected <= '0;
            r_wait     <= 1'b0;
        end else begin
            r_loaded   <= n_loaded;
            r_expected <= n_expected;
            r_wait     <= n_wait;
        end
    end

endmodule

[src/kwm_fifo.sv]
// Two-entry command queue between the front end and the merge engine.
module kwm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kwm_pkg::t_cmd i_data,
    input  logic          i_pop,
    output kwm_pkg::t_cmd o_data,
    output logic          o_valid,
    output logic          o_full
);

    kwm_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;

    assign o_data  = r_slot[r_rd_ptr];
    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/kwm_back.sv]
// Merge engine: head store, sequential minimum scan and the result register.
module kwm_back #(
    parameter int MAX_RUNS = 8,
    parameter int KEY_W    = 64,
    parameter int TAG_W    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [$clog2(MAX_RUNS+1)-1:0]  i_n,
    input  logic                           i_cmd_valid,
    input  kwm_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    output kwm_pkg::t_sel_fb               o_fb,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kwm_pkg::KEY_PORT_W-1:0] o_out_key,
    output logic [kwm_pkg::TAG_PORT_W-1:0] o_out_tag,
    output logic [kwm_pkg::RUN_W-1:0]      o_out_run,
    output logic                           o_merge_done,
    output logic                           o_order_error
);

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int IDX_W = $clog2(MAX_RUNS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [KEY_W-1:0] r_key_mem [MAX_RUNS];
    logic [TAG_W-1:0] r_tag_mem [MAX_RUNS];
    logic [KEY_W-1:0] r_rd_key;
    logic [TAG_W-1:0] r_rd_tag;

    logic [1:0]          r_state, n_state;
    logic [MAX_RUNS-1:0] r_head_valid, n_head_valid;
    logic [CNT_W-1:0]    r_scan_cnt, n_scan_cnt;
    logic                r_rd_live, n_rd_live;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_found, n_found;
    logic [KEY_W-1:0]    r_best_key, n_best_key;
    logic [TAG_W-1:0]    r_best_tag, n_best_tag;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;

    logic                      r_out_valid, n_out_valid;
    logic [KEY_W-1:0]          r_out_key, n_out_key;
    logic [TAG_W-1:0]          r_out_tag, n_out_tag;
    logic [kwm_pkg::RUN_W-1:0] r_out_run, n_out_run;
    logic                      r_out_done, n_out_done;
    logic                      r_out_err, n_out_err;

    logic             out_free;
    logic             wr_en;
    logic [7:0]       cmd_run8;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       best_idx8;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign cmd_run8  = 8'(i_cmd.run);
    assign wr_addr   = cmd_run8[IDX_W-1:0];
    assign rd_addr   = r_scan_cnt[IDX_W-1:0];
    assign best_idx8 = 8'(r_best_idx);

    assign o_out_valid   = r_out_valid;
    assign o_out_key     = kwm_pkg::KEY_PORT_W'(r_out_key);
    assign o_out_tag     = kwm_pkg::TAG_PORT_W'(r_out_tag);
    assign o_out_run     = r_out_run;
    assign o_merge_done  = r_out_done;
    assign o_order_error = r_out_err;

    always_comb begin
        n_state      = r_state;
        n_head_valid = r_head_valid;
        n_scan_cnt   = r_scan_cnt;
        n_rd_live    = r_rd_live;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_best_key   = r_best_key;
        n_best_tag   = r_best_tag;
        n_best_idx   = r_best_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_key    = r_out_key;
        n_out_tag    = r_out_tag;
        n_out_run    = r_out_run;
        n_out_done   = r_out_done;
        n_out_err    = r_out_err;
        o_cmd_pop    = 1'b0;
        wr_en        = 1'b0;
        o_fb         = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        kwm_pkg::CMD_ERR: begin
                            if (out_free) begin
                                o_cmd_pop   = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_key   = '0;
                                n_out_tag   = '0;
                                n_out_run   = '0;
                                n_out_done  = 1'b0;
                                n_out_err   = 1'b1;
                            end
                        end
                        kwm_pkg::CMD_WRITE: begin
                            o_cmd_pop = 1'b1;
                            wr_en     = 1'b1;
                        end
                        kwm_pkg::CMD_WRITE_SEL: begin
                            o_cmd_pop  = 1'b1;
                            wr_en      = 1'b1;
                            n_scan_cnt = '0;
                            n_found    = 1'b0;
                            n_rd_live  = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Compare the entry read in the previous cycle; strict less
                // keeps the lowest run on equal keys.
                if (r_rd_live && (!r_found || (r_rd_key < r_best_key))) begin
                    n_found    = 1'b1;
                    n_best_key = r_rd_key;
                    n_best_tag = r_rd_tag;
                    n_best_idx = r_rd_idx;
                end
                if (r_scan_cnt != i_n) begin
                    n_rd_live  = r_head_valid[rd_addr];
                    n_rd_idx   = rd_addr;
                    n_scan_cnt = r_scan_cnt + CNT_W'(1);
                end else begin
                    n_rd_live = 1'b0;
                    n_state   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_err   = 1'b0;
                    o_fb.valid  = 1'b1;
                    if (r_found) begin
                        n_out_key  = r_best_key;
                        n_out_tag  = r_best_tag;
                        n_out_run  = best_idx8[kwm_pkg::RUN_W-1:0];
                        n_out_done = 1'b0;
                        o_fb.run   = best_idx8[kwm_pkg::RUN_W-1:0];
                    end else begin
                        // Every run is exhausted: report and start a new group.
                        n_out_key    = '0;
                        n_out_tag    = '0;
                        n_out_run    = '0;
                        n_out_done   = 1'b1;
                        o_fb.done    = 1'b1;
                        n_head_valid = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (wr_en) begin
            n_head_valid[wr_addr] = !i_cmd.ended;
        end

        if (i_restart) begin
            n_head_valid = '0;
            n_state      = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head_valid <= '0;
            r_scan_cnt   <= '0;
            r_rd_live    <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= n_head_valid;
            r_scan_cnt   <= n_scan_cnt;
            r_rd_live    <= n_rd_live;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_best_key <= n_best_key;
        r_best_tag <= n_best_tag;
        r_best_idx <= n_best_idx;
        r_out_key  <= n_out_key;
        r_out_tag  <= n_out_tag;
        r_out_run  <= n_out_run;
        r_out_done <= n_out_done;
        r_out_err  <= n_out_err;
    end

    // Head store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= i_cmd.key[KEY_W-1:0];
            r_tag_mem[wr_addr] <= i_cmd.tag[TAG_W-1:0];
        end
        r_rd_key <= r_key_mem[rd_addr];
        r_rd_tag <= r_tag_mem[rd_addr];
    end

endmodule

[test/k_way_run_merge_unit_tb.sv]
// Self-checking testbench of the k-way run merge unit, with a behavioural merge predictor.
module k_way_run_merge_unit_tb;

    localparam int RUN_W      = kwm_pkg::RUN_W;
    localparam int KEY_PORT_W = kwm_pkg::KEY_PORT_W;
    localparam int TAG_PORT_W = kwm_pkg::TAG_PORT_W;
    localparam int CFG_W      = kwm_pkg::CFG_W;

    localparam int NUM_RUNS    = 8;
    localparam int CLK_HALF    = 10;
    localparam int DRAIN_CYC   = 24;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 62;
    localparam int LIMIT_CYC   = 400000;

    typedef struct packed {
        logic [RUN_W-1:0]      run;
        logic [KEY_PORT_W-1:0] key;
        logic [TAG_PORT_W-1:0] tag;
        logic                  ended;
    } t_record;

    typedef struct packed {
        logic [KEY_PORT_W-1:0] key;
        logic [TAG_PORT_W-1:0] tag;
        logic [RUN_W-1:0]      run;
        logic                  done;
        logic                  err;
    } t_emit;

    typedef struct packed {
        logic [NUM_RUNS-1:0][KEY_PORT_W-1:0] key;
        logic [NUM_RUNS-1:0][TAG_PORT_W-1:0] tag;
        logic [NUM_RUNS-1:0]                 vld;
        logic [3:0]                          loaded;
        logic [RUN_W-1:0]                    last_run;
        logic [CFG_W-1:0]                    count;
    } t_merge_state;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [RUN_W-1:0]      i_run_index = '0;
    logic [KEY_PORT_W-1:0] i_record_key = '0;
    logic [TAG_PORT_W-1:0] i_record_tag = '0;
    logic                  i_run_ended = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [KEY_PORT_W-1:0] o_out_key;
    logic [TAG_PORT_W-1:0] o_out_tag;
    logic [RUN_W-1:0]      o_out_run;
    logic                  o_merge_done;
    logic                  o_order_error;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    t_record      pending_records[$];
    t_emit        expected_emits[$];
    t_merge_state live_heads;
    t_merge_state plan_heads;

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    bit hold_begun = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int fail_count = 0;
    int records_sent = 0;
    int records_out = 0;
    int done_seen = 0;
    int errors_seen = 0;
    int cfg_writes = 0;

    k_way_run_merge_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_run_index   (i_run_index),
        .i_record_key  (i_record_key),
        .i_record_tag  (i_record_tag),
        .i_run_ended   (i_run_ended),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_key     (o_out_key),
        .o_out_tag     (o_out_tag),
        .o_out_run     (o_out_run),
        .o_merge_done  (o_merge_done),
        .o_order_error (o_order_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic int active_runs(logic [CFG_W-1:0] count);
        if (count == 0) return 1;
        if (count > NUM_RUNS) return NUM_RUNS;
        return int'(count);
    endfunction

    function automatic t_merge_state fresh_heads(logic [CFG_W-1:0] count);
        t_merge_state s;
        s = '0;
        s.count = count;
        return s;
    endfunction

    // While heads are still being loaded the next run is the load position,
    // afterwards it is the run that was emitted last.
    function automatic logic [RUN_W-1:0] wanted_run(t_merge_state s);
        if (int'(s.loaded) < active_runs(s.count)) return s.loaded[RUN_W-1:0];
        return s.last_run;
    endfunction

    // Applies one record to the head store; returns 1 when it yields an output beat.
    function automatic bit merge_step(inout t_merge_state s, input t_record r,
                                      output t_emit e);
        int n;
        int best;
        bit found;
        logic [RUN_W-1:0] want;
        n = active_runs(s.count);
        want = wanted_run(s);
        e = '0;
        if (r.run != want) begin
            e.err = 1'b1;
            return 1'b1;
        end
        s.vld[want] = !r.ended;
        s.key[want] = r.ended ? '0 : r.key;
        s.tag[want] = r.ended ? '0 : r.tag;
        if (int'(s.loaded) < n) begin
            s.loaded = s.loaded + 1'b1;
            if (int'(s.loaded) < n) return 1'b0;
        end
        found = 1'b0;
        best = 0;
        for (int i = 0; i < n; i++) begin
            if (s.vld[i] && (!found || s.key[i] < s.key[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            e.done = 1'b1;
            s = fresh_heads(s.count);
            return 1'b1;
        end
        e.key = s.key[best];
        e.tag = s.tag[best];
        e.run = RUN_W'(best);
        s.last_run = RUN_W'(best);
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYC * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

    // Sender: offers queued records; the payload is held while the block stalls.
    always @(posedge i_clk) begin : sender
        t_record beat;
        t_emit   res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                beat = {i_run_index, i_record_key, i_record_tag, i_run_ended};
                if (merge_step(live_heads, beat, res)) expected_emits.push_back(res);
                records_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_records.size() > 0) begin
                    beat = pending_records.pop_front();
                    i_run_index  <= beat.run;
                    i_record_key <= beat.key;
                    i_record_tag <= beat.tag;
                    i_run_ended  <= beat.ended;
                    i_in_valid   <= 1'b1;
                    send_gap     <= idle_len(no_idle);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each output beat against the oldest expectation.
    always @(posedge i_clk) begin : receiver
        t_emit got;
        t_emit want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_out_key, o_out_tag, o_out_run, o_merge_done, o_order_error};
                if (expected_emits.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected beat key=%h tag=%h run=%0d done=%b err=%b",
                             $time, got.key, got.tag, got.run, got.done, got.err);
                end else begin
                    want = expected_emits.pop_front();
                    if (got.key != want.key || got.tag != want.tag || got.run != want.run ||
                        got.done != want.done || got.err != want.err) begin
                        fail_count++;
                        $write("%0t: mismatch expected key=%h tag=%h run=%0d done=%b err=%b, ",
                               $time, want.key, want.tag, want.run, want.done, want.err);
                        $display("actual key=%h tag=%h run=%0d done=%b err=%b",
                                 got.key, got.tag, got.run, got.done, got.err);
                    end
                end
                if (got.done) done_seen++;
                else if (got.err) errors_seen++;
                else records_out++;
            end
            // A single long hold-off lets the block back up and stall its input.
            if (hold_req && !hold_begun) begin
                hold_begun  <= 1'b1;
                stall_left  <= LONG_HOLD;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                stall_left  <= idle_len(no_idle);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic add_record(logic [RUN_W-1:0] run, logic [KEY_PORT_W-1:0] key,
                              logic [TAG_PORT_W-1:0] tag, logic ended);
        t_record r;
        t_emit   unused;
        r = {run, key, tag, ended};
        void'(merge_step(plan_heads, r, unused));
        pending_records.push_back(r);
    endtask

    // Sampled at the falling edge so that the sender's updates have settled.
    task automatic wait_idle();
        while (pending_records.size() > 0 || i_in_valid || expected_emits.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_run_count(logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        live_heads = fresh_heads(value);
        plan_heads = fresh_heads(value);
        cfg_writes++;
    endtask

    // Mostly well-formed refills with varied keys, plus some end marks and wrong runs.
    task automatic add_random(int count);
        logic [RUN_W-1:0]      want;
        logic [RUN_W-1:0]      run;
        logic [KEY_PORT_W-1:0] key;
        logic                  ended;
        int r;
        int len;
        bit loading;
        for (int k = 0; k < count; k++) begin
            want = wanted_run(plan_heads);
            loading = int'(plan_heads.loaded) < active_runs(plan_heads.count);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                key = {$urandom, $urandom};
            end else if (r < 55) begin
                key = {8'h61 + 8'($urandom_range(0, 3)), 56'h0};
            end else if (r < 75) begin
                len = $urandom_range(1, 7);
                key = '0;
                for (int b = 0; b < len; b++)
                    key[63 - 8 * b -: 8] = 8'h61 + 8'($urandom_range(0, 25));
            end else if (plan_heads.vld[want]) begin
                key = plan_heads.key[want] + 64'($urandom_range(0, 2));
            end else begin
                key = {$urandom, $urandom};
            end
            ended = $urandom_range(0, 99) < (loading ? 10 : 8);
            run = want;
            if ($urandom_range(0, 99) < 7) run = want + RUN_W'($urandom_range(1, 7));
            add_record(run, key, 16'($urandom_range(0, 65535)), ended);
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] counts [12] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd9,
                                         4'd3, 4'd8, 4'd2, 4'd7, 4'd5, 4'd6};
        int left;
        int chunk;
        int chunk_no;
        live_heads = fresh_heads(4'd2);
        plan_heads = fresh_heads(4'd2);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two runs after reset: extreme keys, ties, wrong runs and group ends.
        add_record(3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
        add_record(3'd1, 64'h0, 16'h0, 1'b0);
        add_record(3'd0, 64'h1234, 16'h5678, 1'b0);
        add_record(3'd1, 64'h6162_6300_0000_0000, 16'h1234, 1'b0);
        add_record(3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 1'b0);
        add_record(3'd0, 64'hDEAD_BEEF_0000_0000, 16'h0, 1'b1);
        add_record(3'd7, 64'h0, 16'h0, 1'b0);
        add_record(3'd1, 64'h0, 16'h0, 1'b1);
        add_record(3'd5, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b0);
        add_record(3'd0, 64'h5555_5555_5555_5555, 16'h5555, 1'b1);
        add_record(3'd1, 64'h5555_5555_5555_5555, 16'hAAAA, 1'b0);
        add_record(3'd1, 64'h0, 16'h0, 1'b1);
        add_record(3'd0, 64'h0, 16'h0, 1'b1);
        add_record(3'd1, 64'h0, 16'h0, 1'b1);
        add_record(3'd0, 64'h6100_0000_0000_0000, 16'h0101, 1'b0);
        add_record(3'd1, 64'h6100_0000_0000_0000, 16'h0202, 1'b0);
        add_record(3'd0, 64'h6100_0000_0000_0000, 16'h0303, 1'b0);

        for (int p = 0; p < 12; p++) begin
            write_run_count(counts[p]);
            left = PHASE_ITEMS;
            chunk_no = 0;
            while (left > 0) begin
                chunk = (p == 0 && chunk_no == 0) ? 40 : $urandom_range(15, 30);
                if (chunk > left) chunk = left;
                no_idle <= (chunk_no % 3 == 2);
                if (p == 0 && chunk_no == 0) hold_req <= 1'b1;
                add_random(chunk);
                // The stimulus waits here until every record is sent and every expected beat has come back.
                wait_idle();
                left -= chunk;
                chunk_no++;
            end
        end
        wait_idle();

        $display("Merged %0d input beats under %0d run count settings.",
                 records_sent, cfg_writes);
        $display("Output beats: %0d records, %0d group ends, %0d order errors.",
                 records_out, done_seen, errors_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
